FILE: src/linear_probe_hash_set_assert.svh
// Assertion macros for the hash set block. They expect clk and arst_n in scope.
`ifndef LINEAR_PROBE_HASH_SET_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_ASSERT_SVH

// Same-cycle implication.
`define LPHS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lphs check failed");

// Next-cycle implication.
`define LPHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lphs check failed");

`endif

FILE: src/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared constants and types of the linear probe hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int DEF_MIN_SIZE = 4;
	localparam int DEF_KEY_BITS = 64;

	localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam int          PADDR_W         = 2;
	localparam logic [3:0]  FILL_RESET      = 4'd6;
	localparam logic [3:0]  FILL_MIN        = 4'd1;
	localparam logic [3:0]  FILL_MAX        = 4'd8;

	localparam logic [1:0] MODE_QUERY  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REHASH = 2'd2;

	typedef struct packed {
		logic        start;
		logic [63:0] key;
	} lphs_hreq_t;

endpackage

FILE: src/lphs_ram.sv
// ----------------------------------------------------------------------------
// lphs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lphs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/lphs_hash.sv
// ----------------------------------------------------------------------------
// lphs_hash
// Multiplicative hash: bits 63:32 of key * HASH_MUL (mod 2^64), built from
// three 32x32 partial products on one shared multiplier, one per cycle.
// ----------------------------------------------------------------------------
module lphs_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  lphs_pkg::lphs_hreq_t req,
	output logic                done,
	output logic [31:0]         hash
);
	import lphs_pkg::*;

	logic [63:0] k_q;
	logic [31:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [31:0] part;

	// cnt 0: kL*cL (high half), cnt 1: kH*cL, cnt 2: kL*cH (low halves)
	always_comb begin
		op_a = (cnt_q == 2'd1) ? k_q[63:32] : k_q[31:0];
		op_b = (cnt_q == 2'd2) ? HASH_MUL[63:32] : HASH_MUL[31:0];
		prod = 64'(op_a) * 64'(op_b);
		part = (cnt_q == 2'd0) ? prod[63:32] : prod[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 2'd2);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			k_q   <= req.key;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part;
		end
	end

	assign done = done_q;
	assign hash = acc_q;

endmodule

FILE: src/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Set of nonzero keys in an open-addressed, linearly probed RAM table that
// doubles from MIN_SIZE up to CAPACITY, rehashing through a spare RAM.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    cmd, key
// out      source     out_valid / out_stall  found, added, table_full, bad_key
// cfg      APB slave  psel/penable/pready    fill_eighths at every address
//
// Query or insert: the key is hashed in the shared 3-pass hash multiplier,
// then each probed slot is read and checked. A growing insert first copies
// the old table into the spare RAM, clears the new table, re-inserts each
// moved key from the spare RAM by hashing and probing, then inserts the new
// key; an empty table is only cleared first. One item at a time; in_stall
// is high from accept until its result is loaded into the output register.
// Zero keys and queries before any table answer without hashing or probing.
// Reset needs no clearing pass: every table growth clears its slots itself.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_assert.svh"

module linear_probe_hash_set #(
	parameter int CAPACITY = lphs_pkg::DEF_CAPACITY,
	parameter int MIN_SIZE = lphs_pkg::DEF_MIN_SIZE,
	parameter int KEY_BITS = lphs_pkg::DEF_KEY_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [63:0]                  key,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic                         added,
	output logic                         table_full,
	output logic                         bad_key,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lphs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import lphs_pkg::*;

	localparam int MAX_SIZE   = 1 << ($clog2(CAPACITY + 1) - 1);
	localparam int AW         = $clog2(MAX_SIZE);
	localparam int SW         = AW + 1;
	localparam int START_RAW  = 1 << $clog2(MIN_SIZE);
	localparam int START_SIZE = (START_RAW < MAX_SIZE) ? START_RAW : MAX_SIZE;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_COPY  = 4'd1;
	localparam logic [3:0] ST_CLEAR = 4'd2;
	localparam logic [3:0] ST_RRD   = 4'd3;
	localparam logic [3:0] ST_RCHK  = 4'd4;
	localparam logic [3:0] ST_HASH  = 4'd5;
	localparam logic [3:0] ST_PRD   = 4'd6;
	localparam logic [3:0] ST_PCHK  = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]          state_q;
	logic                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] pk_q;
	logic [1:0]          mode_q;
	logic [SW-1:0]       size_q;
	logic [SW-1:0]       occ_q;
	logic [SW-1:0]       old_q;
	logic [SW-1:0]       nsize_q;
	logic [SW-1:0]       idx_q;
	logic [SW-1:0]       n_q;
	logic [AW-1:0]       j_q;
	logic [3:0]          fill_q;
	logic                hstart_q;
	logic                copy_v_s1;
	logic [AW-1:0]       copy_a_s1;
	logic                res_found_q, res_added_q, res_full_q, res_bad_q;
	logic                out_valid_q;
	logic                found_q, added_q, full_q, bad_q;

	logic                in_acc;
	logic [KEY_BITS-1:0] keym;
	logic [3:0]          fc;
	logic [SW+2:0]       limit;
	logic                over_fill;
	logic [SW:0]         dbl;
	logic [SW-1:0]       nsize_c;
	logic                grow_need;
	logic [AW-1:0]       mask;
	logic [SW-1:0]       nxt_idx;
	logic                out_free;
	logic                slot_zero;
	logic                slot_hit;
	logic                probe_last;
	logic                cfg_wr;
	logic                hash_go;

	logic                slots_we, slots_re;
	logic [AW-1:0]       slots_waddr, slots_raddr;
	logic [KEY_BITS-1:0] slots_wdata, slots_rdata;
	logic                spare_re;
	logic [KEY_BITS-1:0] spare_rdata;

	lphs_hreq_t          hreq;
	logic                hash_done;
	logic [31:0]         hash_val;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign keym     = key[KEY_BITS-1:0];
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		fc = fill_q;
		if (fill_q < FILL_MIN) fc = FILL_MIN;
		if (fill_q > FILL_MAX) fc = FILL_MAX;
		limit     = ((SW + 3)'(size_q) * (SW + 3)'(fc)) >> 3;
		over_fill = ((SW + 3)'(occ_q) + (SW + 3)'(1)) > limit;
		dbl       = (SW + 1)'(size_q) << 1;
		if (size_q == '0) begin
			nsize_c = SW'(START_SIZE);
		end else if (dbl > (SW + 1)'(MAX_SIZE)) begin
			nsize_c = SW'(MAX_SIZE);
		end else begin
			nsize_c = dbl[SW-1:0];
		end
		grow_need = over_fill && (nsize_c > size_q);
	end

	assign mask       = AW'(size_q - SW'(1));
	assign nxt_idx    = idx_q + SW'(1);
	assign slot_zero  = (slots_rdata == '0);
	assign slot_hit   = (slots_rdata == pk_q);
	assign probe_last = ((n_q + SW'(1)) == size_q);

	// states that launch a hash in the next cycle
	always_comb begin
		case (state_q)
			ST_IDLE: hash_go = in_acc && (keym != '0)
				&& ((cmd == CMD_QUERY) ? (size_q != '0) : !grow_need);
			ST_CLEAR: hash_go = (idx_q == nsize_q) && (old_q == '0);
			ST_RCHK: hash_go = (spare_rdata != '0) || (nxt_idx == old_q);
			ST_PCHK: hash_go = (mode_q == MODE_REHASH) && slot_zero
				&& (nxt_idx == old_q);
			default: hash_go = 1'b0;
		endcase
	end

	// RAM port steering
	always_comb begin
		slots_re    = ((state_q == ST_COPY) && (idx_q < old_q)) || (state_q == ST_PRD);
		slots_raddr = (state_q == ST_COPY) ? idx_q[AW-1:0] : j_q;
		slots_we    = ((state_q == ST_CLEAR) && (idx_q < nsize_q))
			|| ((state_q == ST_PCHK) && slot_zero && (mode_q != MODE_QUERY));
		slots_waddr = (state_q == ST_CLEAR) ? idx_q[AW-1:0] : j_q;
		slots_wdata = (state_q == ST_CLEAR) ? '0 : pk_q;
		spare_re    = (state_q == ST_RRD);
	end

	lphs_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SIZE)) u_slots (
		.clk   (clk),
		.we    (slots_we),
		.waddr (slots_waddr),
		.wdata (slots_wdata),
		.re    (slots_re),
		.raddr (slots_raddr),
		.rdata (slots_rdata)
	);

	lphs_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SIZE)) u_spare (
		.clk   (clk),
		.we    (copy_v_s1),
		.waddr (copy_a_s1),
		.wdata (slots_rdata),
		.re    (spare_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (spare_rdata)
	);

	assign hreq.start = hstart_q;
	assign hreq.key   = 64'(pk_q);

	lphs_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.done   (hash_done),
		.hash   (hash_val)
	);

	// configuration
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = 32'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (cfg_wr) begin
			fill_q <= pwdata[3:0];
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= '0;
			occ_q       <= '0;
			hstart_q    <= 1'b0;
			copy_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hstart_q  <= hash_go;
			copy_v_s1 <= (state_q == ST_COPY) && (idx_q < old_q);
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (keym == '0) begin
							state_q <= ST_FIN;
						end else if (cmd == CMD_QUERY) begin
							if (size_q == '0) begin
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_HASH;
							end
						end else if (grow_need) begin
							state_q <= (size_q == '0) ? ST_CLEAR : ST_COPY;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_COPY: begin
					if (idx_q == old_q) begin
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (idx_q == nsize_q) begin
						size_q <= nsize_q;
						if (old_q == '0) begin
							state_q <= ST_HASH;
						end else begin
							state_q <= ST_RRD;
						end
					end
				end
				ST_RRD: begin
					state_q <= ST_RCHK;
				end
				ST_RCHK: begin
					if ((spare_rdata != '0) || (nxt_idx == old_q)) begin
						state_q <= ST_HASH;
					end else begin
						state_q <= ST_RRD;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_PRD;
					end
				end
				ST_PRD: begin
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					if (mode_q == MODE_REHASH) begin
						if (!slot_zero) begin
							state_q <= ST_PRD;
						end else if (nxt_idx == old_q) begin
							state_q <= ST_HASH;
						end else begin
							state_q <= ST_RRD;
						end
					end else if (slot_hit || slot_zero || probe_last) begin
						if (slot_zero && (mode_q == MODE_INSERT)) begin
							occ_q <= occ_q + SW'(1);
						end
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_PRD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		copy_a_s1 <= idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd_q       <= cmd;
					key_q       <= keym;
					pk_q        <= keym;
					mode_q      <= (cmd == CMD_QUERY) ? MODE_QUERY : MODE_INSERT;
					old_q       <= size_q;
					nsize_q     <= nsize_c;
					idx_q       <= '0;
					res_found_q <= 1'b0;
					res_added_q <= 1'b0;
					res_full_q  <= 1'b0;
					res_bad_q   <= (keym == '0);
				end
			end
			ST_COPY: begin
				idx_q <= (idx_q == old_q) ? '0 : nxt_idx;
			end
			ST_CLEAR: begin
				if (idx_q == nsize_q) begin
					idx_q <= '0;
					if (old_q == '0) begin
						pk_q   <= key_q;
						mode_q <= MODE_INSERT;
					end
				end else begin
					idx_q <= nxt_idx;
				end
			end
			ST_RCHK: begin
				if (spare_rdata != '0) begin
					pk_q   <= spare_rdata;
					mode_q <= MODE_REHASH;
				end else begin
					idx_q <= nxt_idx;
					if (nxt_idx == old_q) begin
						pk_q   <= key_q;
						mode_q <= MODE_INSERT;
					end
				end
			end
			ST_HASH: begin
				j_q <= hash_val[AW-1:0] & mask;
				n_q <= '0;
			end
			ST_PCHK: begin
				if (mode_q == MODE_REHASH) begin
					if (!slot_zero) begin
						j_q <= (j_q + AW'(1)) & mask;
					end else begin
						idx_q <= nxt_idx;
						if (nxt_idx == old_q) begin
							pk_q   <= key_q;
							mode_q <= MODE_INSERT;
						end
					end
				end else begin
					res_found_q <= slot_hit;
					res_added_q <= slot_zero && (mode_q == MODE_INSERT);
					res_full_q  <= !slot_hit && !slot_zero && probe_last
						&& (mode_q == MODE_INSERT);
					n_q <= n_q + SW'(1);
					j_q <= (j_q + AW'(1)) & mask;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					found_q <= res_found_q;
					added_q <= res_added_q && (cmd_q == CMD_INSERT);
					full_q  <= res_full_q;
					bad_q   <= res_bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign added      = added_q;
	assign table_full = full_q;
	assign bad_key    = bad_q;

	`LPHS_ASSERT_NOW(a_one_flag, out_valid_q, $onehot0({found_q, added_q, full_q, bad_q}))
	`LPHS_ASSERT_NOW(a_occ_fits, 1'b1, occ_q <= size_q)
	`LPHS_ASSERT_NOW(a_hash_owner, hash_done, state_q == ST_HASH)
	`LPHS_ASSERT_NEXT(a_grow_wait, (state_q == ST_IDLE) && in_acc && (cmd == CMD_INSERT)
		&& (keym != '0) && grow_need, in_stall)

endmodule
